FILE: rtl/core/e2c_pkg.sv
`timescale 1ns / 1ps
package e2c_pkg;

	localparam int MAX_DIM = 4096;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int DIM_W = 13;
	localparam int FS_W = 12;
	localparam int CRD_W = 20;
	localparam int ANG_W = 18;
	localparam int DIV_W = 18;
	localparam int DIV_NUM_W = 29;
	localparam int SQ_RAD_W = 36;
	localparam int SQ_ROOT_W = 18;
	localparam int SQ_STEPS = 18;
	localparam int DIV_STEPS = 18;
	localparam logic signed [CRD_W-1:0] ONE_Q16 = 20'sd65536;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd16384;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 18'sd32768;

	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef enum logic [0:0] {
		REG_PAN_WIDTH = 1'b0,
		REG_PAN_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic oof;
		logic bad_face;
		logic [2:0] face;
		logic [10:0] col;
		logic [10:0] row;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [FS_W-1:0] fs;
	} tag_t;

	function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
		logic signed [ANG_W-1:0] t;
		begin
			case (i)
				0: t = 18'sd8192;
				1: t = 18'sd4836;
				2: t = 18'sd2555;
				3: t = 18'sd1297;
				4: t = 18'sd651;
				5: t = 18'sd326;
				6: t = 18'sd163;
				7: t = 18'sd81;
				8: t = 18'sd41;
				9: t = 18'sd20;
				10: t = 18'sd10;
				11: t = 18'sd5;
				12: t = 18'sd3;
				13: t = 18'sd1;
				14: t = 18'sd1;
				default: t = 18'sd0;
			endcase
			return t;
		end
	endfunction

endpackage

FILE: rtl/core/e2c_div_cell.sv
`timescale 1ns / 1ps
module e2c_div_cell import e2c_pkg::*; (
	input logic clk,
	input logic en,
	input logic [DIV_W-1:0] rem_in,
	input logic [DIV_NUM_W-1:0] num_in,
	input logic [DIV_W-1:0] quo_in,
	input logic [FS_W-1:0] den,
	output logic [DIV_W-1:0] rem_out,
	output logic [DIV_NUM_W-1:0] num_out,
	output logic [DIV_W-1:0] quo_out
);

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;

	always_comb begin
		trial = {rem_in, num_in[DIV_NUM_W-1]};
		diff = trial - {{(DIV_W+1-FS_W){1'b0}}, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= {num_in[DIV_NUM_W-2:0], 1'b0};
			if (!diff[DIV_W]) begin
				rem_out <= diff[DIV_W-1:0];
				quo_out <= {quo_in[DIV_W-2:0], 1'b1};
			end else begin
				rem_out <= trial[DIV_W-1:0];
				quo_out <= {quo_in[DIV_W-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: rtl/core/e2c_sqrt_cell.sv
`timescale 1ns / 1ps
module e2c_sqrt_cell import e2c_pkg::*; (
	input logic clk,
	input logic en,
	input logic [SQ_RAD_W-1:0] rad_in,
	input logic [SQ_ROOT_W+1:0] rem_in,
	input logic [SQ_ROOT_W-1:0] root_in,
	output logic [SQ_RAD_W-1:0] rad_out,
	output logic [SQ_ROOT_W+1:0] rem_out,
	output logic [SQ_ROOT_W-1:0] root_out
);

	logic [SQ_ROOT_W+1:0] trial;
	logic [SQ_ROOT_W+1:0] sub;
	logic [SQ_ROOT_W+2:0] diff;

	always_comb begin
		trial = {rem_in[SQ_ROOT_W-1:0], rad_in[SQ_RAD_W-1 -: 2]};
		sub = {root_in, 2'b01};
		diff = {1'b0, trial} - {1'b0, sub};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out <= {rad_in[SQ_RAD_W-3:0], 2'b00};
			if (!diff[SQ_ROOT_W+2]) begin
				rem_out <= diff[SQ_ROOT_W+1:0];
				root_out <= {root_in[SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_out <= trial;
				root_out <= {root_in[SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: rtl/core/e2c_cordic_cell.sv
`timescale 1ns / 1ps
module e2c_cordic_cell import e2c_pkg::*; (
	input logic clk,
	input logic en,
	input logic [4:0] step,
	input logic signed [CRD_W+1:0] x_in,
	input logic signed [CRD_W+1:0] y_in,
	input logic signed [ANG_W-1:0] ang_in,
	output logic signed [CRD_W+1:0] x_out,
	output logic signed [CRD_W+1:0] y_out,
	output logic signed [ANG_W-1:0] ang_out
);

	logic signed [CRD_W+1:0] dx;
	logic signed [CRD_W+1:0] dy;
	logic signed [ANG_W-1:0] da;

	always_comb begin
		dx = y_in >>> step;
		dy = x_in >>> step;
		da = atan_turn(int'(step));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				ang_out <= ang_in + da;
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				ang_out <= ang_in - da;
			end
		end
	end

endmodule

FILE: rtl/core/equirect_to_cubemap_address.sv
`timescale 1ns / 1ps
// Streaming cubemap-to-panorama address generator. One transaction is accepted
// per clock while out_stall is low, and results leave in order through a capture stage, two
// 18-cell restoring divider chains for the face coordinates, a direction stage and
// a squaring stage, an 18-cell square-root chain for the horizontal radius, a
// CORDIC setup stage, two 16-cell CORDIC chains for the azimuth and polar angle,
// and four scaling, clamping and index stages. A stall on the output freezes the
// whole pipeline, so the input stall equals the output stall. Configuration takes
// effect for transactions accepted after the write.
module equirect_to_cubemap_address import e2c_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [12:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] face,
	input logic [10:0] col,
	input logic [10:0] row,
	output logic out_valid,
	input logic out_stall,
	output logic [11:0] src_col,
	output logic [11:0] src_row,
	output logic [23:0] src_index,
	output logic [24:0] dst_index,
	output logic out_of_face
);

	localparam int NS = 1 + DIV_STEPS + 2 + SQ_STEPS + 1 + CORDIC_STEPS + 4;

	logic [DIM_W-1:0] pan_width_q;
	logic [DIM_W-1:0] pan_height_q;
	logic adv;
	tag_t tag_s [NS+1];
	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic [FS_W-1:0] fs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_width_q <= 13'd2048;
			pan_height_q <= 13'd1024;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAN_WIDTH: pan_width_q <= cfg_data;
				REG_PAN_HEIGHT: pan_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !out_stall;
	assign in_stall = out_stall;

	always_comb begin
		w_c = pan_width_q;
		if (w_c == '0) w_c = 13'd1;
		if (w_c > 13'(MAX_DIM)) w_c = 13'(MAX_DIM);
		h_c = pan_height_q;
		if (h_c < 13'd2) h_c = 13'd2;
		if (h_c > 13'(MAX_DIM)) h_c = 13'(MAX_DIM);
		fs_c = h_c[DIM_W-1:1];
	end

	always_comb begin
		tag_s[0].valid = in_valid;
		tag_s[0].face = face;
		tag_s[0].col = col;
		tag_s[0].row = row;
		tag_s[0].w = w_c;
		tag_s[0].h = h_c;
		tag_s[0].fs = fs_c;
		tag_s[0].oof = ({1'b0, col} >= fs_c) || ({1'b0, row} >= fs_c);
		tag_s[0].bad_face = face > 3'd5;
	end

	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_tag
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) tag_s[g+1].valid <= 1'b0;
				else if (adv) tag_s[g+1] <= tag_s[g];
			end
		end
	endgenerate

	// Dividers: two chains (u numerator and v numerator), run side by side.
	logic [DIV_W-1:0] ur [DIV_STEPS+1];
	logic [DIV_NUM_W-1:0] un [DIV_STEPS+1];
	logic [DIV_W-1:0] uq [DIV_STEPS+1];
	logic [DIV_W-1:0] vr [DIV_STEPS+1];
	logic [DIV_NUM_W-1:0] vn [DIV_STEPS+1];
	logic [DIV_W-1:0] vq [DIV_STEPS+1];
	logic [DIV_W-1:0] ur_o [DIV_STEPS];
	logic [DIV_NUM_W-1:0] un_o [DIV_STEPS];
	logic [DIV_W-1:0] uq_o [DIV_STEPS];
	logic [DIV_W-1:0] vr_o [DIV_STEPS];
	logic [DIV_NUM_W-1:0] vn_o [DIV_STEPS];
	logic [DIV_W-1:0] vq_o [DIV_STEPS];

	// Numerator (2n+1)<<16 is at most 29 bits; quotient is below 2^17 inside the face.
	// Its upper 11 bits stay below the face size, so they are preloaded as the
	// remainder and only the lower 18 bits pass through the chain.
	always_ff @(posedge clk) begin
		if (adv) begin
			ur[0] <= DIV_W'({1'b0, col[10:1]});
			uq[0] <= '0;
			un[0] <= {col[0], 1'b1, 16'd0, 11'd0};
			vr[0] <= DIV_W'({1'b0, row[10:1]});
			vq[0] <= '0;
			vn[0] <= {row[0], 1'b1, 16'd0, 11'd0};
		end
	end

	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_div
			e2c_div_cell u_du (
				.clk(clk), .en(adv), .rem_in(ur[g]), .num_in(un[g]), .quo_in(uq[g]),
				.den(tag_s[g+1].fs), .rem_out(ur_o[g]), .num_out(un_o[g]),
				.quo_out(uq_o[g])
			);
			e2c_div_cell u_dv (
				.clk(clk), .en(adv), .rem_in(vr[g]), .num_in(vn[g]), .quo_in(vq[g]),
				.den(tag_s[g+1].fs), .rem_out(vr_o[g]), .num_out(vn_o[g]),
				.quo_out(vq_o[g])
			);
			assign ur[g+1] = ur_o[g];
			assign un[g+1] = un_o[g];
			assign uq[g+1] = uq_o[g];
			assign vr[g+1] = vr_o[g];
			assign vn[g+1] = vn_o[g];
			assign vq[g+1] = vq_o[g];
		end
	endgenerate

	// Stage after divider: form direction.
	localparam int SD = 1 + DIV_STEPS;
	logic signed [CRD_W-1:0] uc;
	logic signed [CRD_W-1:0] vc;
	logic signed [CRD_W-1:0] dx_s1, dy_s1, dz_s1;
	always_comb begin
		uc = $signed({2'b00, uq[DIV_STEPS]}) - ONE_Q16;
		vc = ONE_Q16 - $signed({2'b00, vq[DIV_STEPS]});
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= '0; dy_s1 <= '0; dz_s1 <= '0;
			case (tag_s[SD].face)
				FACE_PX: begin dx_s1 <= ONE_Q16; dy_s1 <= vc; dz_s1 <= -uc; end
				FACE_NX: begin dx_s1 <= -ONE_Q16; dy_s1 <= vc; dz_s1 <= uc; end
				FACE_PY: begin dx_s1 <= uc; dy_s1 <= ONE_Q16; dz_s1 <= -vc; end
				FACE_NY: begin dx_s1 <= uc; dy_s1 <= -ONE_Q16; dz_s1 <= vc; end
				FACE_PZ: begin dx_s1 <= uc; dy_s1 <= vc; dz_s1 <= ONE_Q16; end
				FACE_NZ: begin dx_s1 <= -uc; dy_s1 <= vc; dz_s1 <= -ONE_Q16; end
				default: ;
			endcase
		end
	end

	logic [SQ_RAD_W-1:0] sq_s2;
	logic signed [CRD_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [SQ_RAD_W-1:0] xx, zz;
	always_comb begin
		xx = SQ_RAD_W'($unsigned(SQ_RAD_W'(dx_s1) * SQ_RAD_W'(dx_s1)));
		zz = SQ_RAD_W'($unsigned(SQ_RAD_W'(dz_s1) * SQ_RAD_W'(dz_s1)));
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2 <= xx + zz;
			dx_s2 <= dx_s1; dy_s2 <= dy_s1; dz_s2 <= dz_s1;
		end
	end

	// Square-root chain; direction components ride alongside.
	logic [SQ_RAD_W-1:0] rad [SQ_STEPS+1];
	logic [SQ_ROOT_W+1:0] srem [SQ_STEPS+1];
	logic [SQ_ROOT_W-1:0] sroot [SQ_STEPS+1];
	logic signed [CRD_W-1:0] sx [SQ_STEPS+1];
	logic signed [CRD_W-1:0] sy [SQ_STEPS+1];
	logic signed [CRD_W-1:0] sz [SQ_STEPS+1];
	assign rad[0] = sq_s2;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sx[0] = dx_s2;
	assign sy[0] = dy_s2;
	assign sz[0] = dz_s2;
	generate
		for (g = 0; g < SQ_STEPS; g++) begin : g_sq
			logic [SQ_RAD_W-1:0] ro;
			logic [SQ_ROOT_W+1:0] re;
			logic [SQ_ROOT_W-1:0] rt;
			e2c_sqrt_cell u_sq (
				.clk(clk), .en(adv), .rad_in(rad[g]), .rem_in(srem[g]),
				.root_in(sroot[g]), .rad_out(ro), .rem_out(re),
				.root_out(rt)
			);
			assign rad[g+1] = ro;
			assign srem[g+1] = re;
			assign sroot[g+1] = rt;
			always_ff @(posedge clk) begin
				if (adv) begin
					sx[g+1] <= sx[g]; sy[g+1] <= sy[g]; sz[g+1] <= sz[g];
				end
			end
		end
	endgenerate

	// CORDIC setup: two chains with quarter-turn pre-rotation.
	logic signed [CRD_W+1:0] px0, py0, tx0, ty0;
	logic signed [ANG_W-1:0] pa0, ta0;
	logic pz0, tz0;
	always_ff @(posedge clk) begin
		logic signed [CRD_W+1:0] ax, ay, bx, by;
		ax = (CRD_W+2)'(sx[SQ_STEPS]);
		ay = (CRD_W+2)'(sz[SQ_STEPS]);
		bx = (CRD_W+2)'(sy[SQ_STEPS]);
		by = $signed({4'd0, sroot[SQ_STEPS]});
		if (adv) begin
			pz0 <= (ax == 0) && (ay == 0);
			tz0 <= (bx == 0) && (by == 0);
			px0 <= ax; py0 <= ay; pa0 <= '0;
			if (ax < 0) begin
				if (ay >= 0) begin px0 <= ay; py0 <= -ax; pa0 <= QUARTER_TURN; end
				else begin px0 <= -ay; py0 <= ax; pa0 <= -QUARTER_TURN; end
			end
			tx0 <= bx; ty0 <= by; ta0 <= '0;
			if (bx < 0) begin
				if (by >= 0) begin tx0 <= by; ty0 <= -bx; ta0 <= QUARTER_TURN; end
				else begin tx0 <= -by; ty0 <= bx; ta0 <= -QUARTER_TURN; end
			end
		end
	end

	logic signed [CRD_W+1:0] cpx [CORDIC_STEPS+1];
	logic signed [CRD_W+1:0] cpy [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] cpa [CORDIC_STEPS+1];
	logic signed [CRD_W+1:0] ctx [CORDIC_STEPS+1];
	logic signed [CRD_W+1:0] cty [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] cta [CORDIC_STEPS+1];
	logic cpz [CORDIC_STEPS+1];
	logic ctz [CORDIC_STEPS+1];
	assign cpx[0] = px0; assign cpy[0] = py0; assign cpa[0] = pa0;
	assign ctx[0] = tx0; assign cty[0] = ty0; assign cta[0] = ta0;
	assign cpz[0] = pz0; assign ctz[0] = tz0;
	generate
		for (g = 0; g < CORDIC_STEPS; g++) begin : g_cor
			logic signed [CRD_W+1:0] pxo, pyo, txo, tyo;
			logic signed [ANG_W-1:0] pao, tao;
			e2c_cordic_cell u_cp (
				.clk(clk), .en(adv), .step(5'(g)), .x_in(cpx[g]),
				.y_in(cpy[g]), .ang_in(cpa[g]),
				.x_out(pxo), .y_out(pyo), .ang_out(pao)
			);
			e2c_cordic_cell u_ct (
				.clk(clk), .en(adv), .step(5'(g)), .x_in(ctx[g]),
				.y_in(cty[g]), .ang_in(cta[g]),
				.x_out(txo), .y_out(tyo), .ang_out(tao)
			);
			assign cpx[g+1] = pxo; assign cpy[g+1] = pyo; assign cpa[g+1] = pao;
			assign ctx[g+1] = txo; assign cty[g+1] = tyo; assign cta[g+1] = tao;
			always_ff @(posedge clk) begin
				if (adv) begin
					cpz[g+1] <= cpz[g];
					ctz[g+1] <= ctz[g];
				end
			end
		end
	endgenerate

	// Scale and clamp.
	localparam int SE = SD + 2 + SQ_STEPS + 1 + CORDIC_STEPS;
	logic signed [ANG_W-1:0] phi_c, th_c;
	logic signed [ANG_W+1:0] fx, fy;
	logic signed [ANG_W+DIM_W+2:0] ppx_s1, ppy_s1;
	always_comb begin
		phi_c = cpz[CORDIC_STEPS] ? '0 : cpa[CORDIC_STEPS];
		th_c = ctz[CORDIC_STEPS] ? '0 : cta[CORDIC_STEPS];
		if (tag_s[SE].bad_face) begin
			phi_c = '0;
			th_c = QUARTER_TURN;
		end
		fx = (ANG_W+2)'(HALF_TURN) - (ANG_W+2)'(phi_c);
		fy = (ANG_W+2)'(th_c) <<< 1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ppx_s1 <= fx * $signed({1'b0, tag_s[SE].w});
			ppy_s1 <= fy * $signed({1'b0, tag_s[SE].h});
		end
	end

	logic [11:0] cx_s2, cy_s2;
	always_ff @(posedge clk) begin
		logic signed [ANG_W+DIM_W+2:0] vx, vy;
		vx = ppx_s1 < 0 ? '0 : ppx_s1 >>> 16;
		vy = ppy_s1 < 0 ? '0 : ppy_s1 >>> 16;
		if (vx > $signed({1'b0, tag_s[SE+1].w}) - 1) vx = $signed({1'b0, tag_s[SE+1].w}) - 1;
		if (vy > $signed({1'b0, tag_s[SE+1].h}) - 1) vy = $signed({1'b0, tag_s[SE+1].h}) - 1;
		if (adv) begin
			cx_s2 <= vx[11:0];
			cy_s2 <= vy[11:0];
		end
	end

	logic [23:0] si_s3;
	logic [24:0] fsq_s3;
	logic [24:0] rf_s3;
	logic [11:0] cx_s3, cy_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			si_s3 <= 24'(cy_s2 * tag_s[SE+2].w + cx_s2);
			fsq_s3 <= 25'(tag_s[SE+2].fs * tag_s[SE+2].fs);
			rf_s3 <= 25'(tag_s[SE+2].row * tag_s[SE+2].fs + tag_s[SE+2].col);
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_col <= tag_s[SE+3].oof ? '0 : cx_s3;
			src_row <= tag_s[SE+3].oof ? '0 : cy_s3;
			src_index <= tag_s[SE+3].oof ? '0 : si_s3;
			dst_index <= tag_s[SE+3].oof ? '0 :
				25'(tag_s[SE+3].face * fsq_s3 + rf_s3);
			out_of_face <= tag_s[SE+3].oof;
		end
	end
	assign out_valid = tag_s[NS].valid;

	a_oof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_face |-> src_index == 0 && dst_index == 0)
		else $error("out-of-face result carries an address");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(src_index))
		else $error("stalled result changed");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({src_col, src_row, src_index, dst_index, out_of_face}))
		else $error("result carries unknown bits");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import e2c_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] FACE_UNDEF_LO = 3'd6;
	localparam logic [2:0] FACE_UNDEF_HI = 3'd7;

	typedef struct {
		logic [2:0] face;
		logic [10:0] col;
		logic [10:0] row;
	} pixel_t;

	typedef struct {
		logic [11:0] src_col;
		logic [11:0] src_row;
		logic [23:0] src_index;
		logic [24:0] dst_index;
		logic out_of_face;
	} src_addr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] face = '0;
	logic [10:0] col = '0;
	logic [10:0] row = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [11:0] src_col;
	logic [11:0] src_row;
	logic [23:0] src_index;
	logic [24:0] dst_index;
	logic out_of_face;

	pixel_t pixel_q[$];
	src_addr_t addr_q[$];
	logic [12:0] width_reg = 13'd2048;
	logic [12:0] height_reg = 13'd1024;
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int hold_cnt = 0;
	bit hold_armed = 0;
	bit hold_done = 0;

	equirect_to_cubemap_address dut (.*);

	always #2 clk = ~clk;

	function automatic longint eff_width();
		longint w;
		w = longint'(width_reg);
		if (w < 1) w = 1;
		if (w > MAX_DIM) w = MAX_DIM;
		return w;
	endfunction

	function automatic longint eff_height();
		longint h;
		h = longint'(height_reg);
		if (h < 2) h = 2;
		if (h > MAX_DIM) h = MAX_DIM;
		return h;
	endfunction

	function automatic longint floor_sqrt(input longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint turn_atan2(input longint y, input longint x);
		longint arc_step[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
			3, 1, 1, 0};
		longint a, t, dx, dy;
		a = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; a = 16384;
			end else begin
				x = -y; y = t; a = -16384;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; a += arc_step[i];
			end else begin
				x -= dx; y += dy; a -= arc_step[i];
			end
		end
		return a;
	endfunction

	function automatic longint scale_dim(input longint frac, input longint dim);
		longint p, v;
		p = frac * dim;
		v = (p < 0) ? 0 : (p >>> 16);
		if (v > dim - 1) v = dim - 1;
		return v;
	endfunction

	function automatic src_addr_t panorama_source(input pixel_t p);
		src_addr_t e;
		longint w, h, fs, c, r, f, uc, vc, x, y, z, rad, phi, theta, px, py;
		w = eff_width();
		h = eff_height();
		fs = h >>> 1;
		c = longint'(p.col);
		r = longint'(p.row);
		f = longint'(p.face);
		x = 0; y = 0; z = 0;
		if (c >= fs || r >= fs) begin
			e = '{12'd0, 12'd0, 24'd0, 25'd0, 1'b1};
			return e;
		end
		uc = ((2 * c + 1) * 65536) / fs - 65536;
		vc = 65536 - ((2 * r + 1) * 65536) / fs;
		case (p.face)
			FACE_PX: begin x = 65536; y = vc; z = -uc; end
			FACE_NX: begin x = -65536; y = vc; z = uc; end
			FACE_PY: begin x = uc; y = 65536; z = -vc; end
			FACE_NY: begin x = uc; y = -65536; z = vc; end
			FACE_PZ: begin x = uc; y = vc; z = 65536; end
			FACE_NZ: begin x = -uc; y = vc; z = -65536; end
			default: ;
		endcase
		if (f <= 5) begin
			rad = floor_sqrt(x * x + z * z);
			phi = turn_atan2(z, x);
			theta = turn_atan2(rad, y);
		end else begin
			phi = 0;
			theta = 16384;
		end
		px = scale_dim(32768 - phi, w);
		py = scale_dim(2 * theta, h);
		e.src_col = px[11:0];
		e.src_row = py[11:0];
		px = py * w + px;
		e.src_index = px[23:0];
		py = f * fs * fs + r * fs + c;
		e.dst_index = py[24:0];
		e.out_of_face = 1'b0;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				p.face = face;
				p.col = col;
				p.row = row;
				addr_q.insert(addr_q.size(), panorama_source(p));
			end
			if (!in_valid || !in_stall) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					p = pixel_q.pop_front();
					in_valid <= 1'b1;
					face <= p.face;
					col <= p.col;
					row <= p.row;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		src_addr_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (addr_q.size() == 0) begin
					$error("result with no expected transaction");
					errors++;
				end else begin
					e = addr_q.pop_front();
					if (src_col !== e.src_col) begin
						$error("src_col expected %0d got %0d", e.src_col, src_col);
						errors++;
					end
					if (src_row !== e.src_row) begin
						$error("src_row expected %0d got %0d", e.src_row, src_row);
						errors++;
					end
					if (src_index !== e.src_index) begin
						$error("src_index expected %0d got %0d", e.src_index, src_index);
						errors++;
					end
					if (dst_index !== e.dst_index) begin
						$error("dst_index expected %0d got %0d", e.dst_index, dst_index);
						errors++;
					end
					if (out_of_face !== e.out_of_face) begin
						$error("out_of_face expected %0d got %0d", e.out_of_face,
							out_of_face);
						errors++;
					end
				end
			end
			if (hold_armed && !hold_done) begin
				hold_done = 1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic drain();
		while (pixel_q.size() > 0 || addr_q.size() > 0 || in_valid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [12:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PAN_WIDTH) width_reg = v;
		else height_reg = v;
	endtask

	task automatic push_pixel(input logic [2:0] f, input logic [10:0] c, input logic [10:0] r);
		pixel_t p;
		p.face = f;
		p.col = c;
		p.row = r;
		pixel_q.insert(pixel_q.size(), p);
	endtask

	task automatic push_random(input int n);
		int k, fs;
		fs = int'(eff_height() >>> 1);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 75)
				push_pixel(3'($urandom_range(5)), 11'($urandom_range(fs - 1)),
					11'($urandom_range(fs - 1)));
			else if (k < 85)
				push_pixel(3'($urandom_range(FACE_UNDEF_HI, FACE_UNDEF_LO)),
					11'($urandom_range(fs - 1)), 11'($urandom_range(fs - 1)));
			else
				push_pixel(3'($urandom_range(7)), 11'($urandom_range(2047)),
					11'($urandom_range(2047)));
		end
	endtask

	task automatic run_phase(input logic [12:0] w, input logic [12:0] h, input int ip,
		input int sp, input int n);
		drain();
		write_reg(REG_PAN_WIDTH, w);
		write_reg(REG_PAN_HEIGHT, h);
		idle_pct = ip;
		stall_pct = sp;
		push_random(n);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default geometry, face size 512: every face, corners and outside the face.
		push_pixel(FACE_PX, 11'd0, 11'd0);
		push_pixel(FACE_NX, 11'd511, 11'd511);
		push_pixel(FACE_PY, 11'd256, 11'd255);
		push_pixel(FACE_NY, 11'd0, 11'd511);
		push_pixel(FACE_PZ, 11'd511, 11'd0);
		push_pixel(FACE_NZ, 11'd255, 11'd256);
		push_pixel(FACE_UNDEF_LO, 11'd100, 11'd200);
		push_pixel(FACE_UNDEF_HI, 11'd511, 11'd511);
		push_pixel(FACE_PX, 11'd512, 11'd0);
		push_pixel(FACE_PZ, 11'd0, 11'd512);
		push_pixel(FACE_NZ, 11'd2047, 11'd2047);
		push_pixel(FACE_NX, 11'd256, 11'd256);
		drain();

		// A face size of one puts the Y face centers on the zero azimuth vector.
		write_reg(REG_PAN_WIDTH, 13'd0);
		write_reg(REG_PAN_HEIGHT, 13'd0);
		push_pixel(FACE_PY, 11'd0, 11'd0);
		push_pixel(FACE_NY, 11'd0, 11'd0);
		push_pixel(FACE_PX, 11'd0, 11'd0);
		push_pixel(FACE_UNDEF_HI, 11'd0, 11'd0);
		push_pixel(FACE_PZ, 11'd1, 11'd0);
		push_pixel(FACE_NX, 11'd0, 11'd1);
		drain();

		write_reg(REG_PAN_WIDTH, 13'd8191);
		write_reg(REG_PAN_HEIGHT, 13'd4096);
		push_pixel(FACE_PX, 11'd2047, 11'd2047);
		push_pixel(FACE_NZ, 11'd2047, 11'd0);
		push_pixel(FACE_UNDEF_HI, 11'd2047, 11'd2047);
		push_random(70);

		run_phase(13'd4096, 13'd4096, 79, 0, 90);
		run_phase(13'd0, 13'd1, 0, 79, 60);
		run_phase(13'd8191, 13'd8191, 33, 33, 90);
		run_phase(13'd1, 13'd2, 0, 0, 40);
		run_phase(13'd2048, 13'd2048, 0, 0, 90);
		repeat (20) @(posedge clk);
		hold_armed = 1;
		run_phase(13'd640, 13'd320, 79, 0, 60);
		run_phase(13'd3000, 13'd4095, 0, 79, 70);
		run_phase(13'd1234, 13'd603, 33, 33, 70);
		drain();

		if (errors == 0 && addr_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
